// ===== hdl/srn_pkg.sv =====
// shared types and constants for the sparse row l2 normalizer
// depends on nothing; used by srn_ctrl, srn_dpath and sparse_row_l2_normalizer
package srn_pkg;

    localparam int MAX_ROW_NNZ_DEF = 64;
    localparam int VAL_W      = 16;
    localparam int COL_W      = 16;
    localparam int SUM_W      = 37;
    localparam int SQ_W       = 31;
    localparam int DVD_W      = 64;
    localparam int REM_W      = 38;
    localparam int ROOT_W     = 32;
    localparam int SREM_W     = 36;
    localparam int DIV_STEPS  = 63;
    localparam int SQRT_STEPS = 32;
    localparam int STEP_W     = 6;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [COL_W-1:0]        column;
        logic                    last_in_row;
    } in_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] scaled_value;
        logic [COL_W-1:0]        out_column;
        logic                    last_of_row;
        logic [SUM_W-1:0]        row_sum_squares;
        logic                    zero_row;
        logic                    row_overflow;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic rd;
        logic mul;
        logic div_step;
        logic sqrt_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic in_last;
        logic zero_sum;
        logic last_elem;
        logic out_free;
    } status_t;

endpackage

// ===== hdl/srn_ctrl.sv =====
// sequencer for the row normalizer: load, read back, multiply, divide, square root, emit
// depends on srn_pkg
module srn_ctrl
    import srn_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t st,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DIV,
        S_SQRT,
        S_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid && st.in_last)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                cnt_next   = '0;
                state_next = st.zero_sum ? S_EMIT : S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = st.last_elem ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !in_stall)
        else $error("load while busy");
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> cnt_reg < STEP_W'(DIV_STEPS))
        else $error("divide step count out of range");
    a_emit_then_read: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && !st.last_elem) |=> state_reg == S_READ)
        else $error("emit not followed by read");

endmodule

// ===== hdl/srn_dpath.sv =====
// row buffer, sum of squares, bit-serial divider and square root, output register
// depends on srn_pkg
module srn_dpath
    import srn_pkg::*;
#(
    parameter int MAX_ROW_NNZ = MAX_ROW_NNZ_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_data,
    input  cmd_t      cmd,
    output status_t   st,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam int IDX_W = (MAX_ROW_NNZ > 1) ? $clog2(MAX_ROW_NNZ) : 1;
    localparam int CNT_W = $clog2(MAX_ROW_NNZ + 1);

    logic [VAL_W-1:0] vmem [MAX_ROW_NNZ];
    logic [COL_W-1:0] cmem [MAX_ROW_NNZ];

    logic [CNT_W-1:0]  count_reg;
    logic [SUM_W-1:0]  acc_reg;
    logic              ovf_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [VAL_W-1:0]  val_rd_reg;
    logic [COL_W-1:0]  col_rd_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [REM_W-2:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [SREM_W-1:0] srem_reg;
    out_item_t         out_reg;
    logic              out_valid_reg;

    logic [VAL_W-1:0]  mag_in, mag_rd;
    logic [2*VAL_W-1:0] sq_in, sq_rd;
    logic              room;
    logic [REM_W-1:0]  rem_sh;
    logic              rem_ge;
    logic [SREM_W-1:0] srem_sh, trial;
    logic              srem_ge;
    logic [ROOT_W:0]   q_full;
    logic [ROOT_W-1:0] q;
    logic              neg;
    logic [VAL_W-1:0]  scaled;

    assign mag_in = in_data.value[VAL_W-1] ? (~in_data.value + 1'b1) : in_data.value;
    assign mag_rd = val_rd_reg[VAL_W-1] ? (~val_rd_reg + 1'b1) : val_rd_reg;
    assign sq_in  = mag_in * mag_in;
    assign sq_rd  = mag_rd * mag_rd;
    assign room   = (count_reg < CNT_W'(MAX_ROW_NNZ));

    assign rem_sh = {rem_reg, dvd_reg[DVD_W-2]};
    assign rem_ge = (rem_sh >= {1'b0, acc_reg});

    assign srem_sh = {srem_reg[SREM_W-3:0], dvd_reg[DVD_W-1:DVD_W-2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign srem_ge = (srem_sh >= trial);

    assign q_full = ({1'b0, root_reg} + 1'b1) >> 1;
    assign q      = q_full[ROOT_W-1:0];
    assign neg    = val_rd_reg[VAL_W-1];

    always_comb
    begin
        if (acc_reg == '0)
        begin
            scaled = '0;
        end
        else if (neg)
        begin
            scaled = (q > ROOT_W'(32768)) ? 16'h8000 : (~q[VAL_W-1:0] + 1'b1);
        end
        else
        begin
            scaled = (q > ROOT_W'(32767)) ? 16'h7fff : q[VAL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && room)
        begin
            vmem[count_reg[IDX_W-1:0]] <= in_data.value;
            cmem[count_reg[IDX_W-1:0]] <= in_data.column;
        end
        if (cmd.rd)
        begin
            val_rd_reg <= vmem[idx_reg];
            col_rd_reg <= cmem[idx_reg];
        end
        if (cmd.mul)
        begin
            dvd_reg  <= {1'b0, sq_rd[SQ_W-1:0], 32'b0};
            rem_reg  <= '0;
            root_reg <= '0;
            srem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? (REM_W-1)'(rem_sh - {1'b0, acc_reg}) : rem_sh[REM_W-2:0];
            dvd_reg <= {1'b0, dvd_reg[DVD_W-3:0], rem_ge};
        end
        else if (cmd.sqrt_step)
        begin
            srem_reg <= srem_ge ? (srem_sh - trial) : srem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], srem_ge};
            dvd_reg  <= {dvd_reg[DVD_W-3:0], 2'b00};
        end
        if (cmd.emit)
        begin
            out_reg.scaled_value    <= scaled;
            out_reg.out_column      <= col_rd_reg;
            out_reg.last_of_row     <= st.last_elem;
            out_reg.row_sum_squares <= acc_reg;
            out_reg.zero_row        <= (acc_reg == '0);
            out_reg.row_overflow    <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (room)
                begin
                    count_reg <= count_reg + 1'b1;
                    acc_reg   <= acc_reg + SUM_W'(sq_in[SQ_W-1:0]);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                if (st.last_elem)
                begin
                    idx_reg   <= '0;
                    count_reg <= '0;
                    acc_reg   <= '0;
                    ovf_reg   <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign st.in_last   = in_data.last_in_row;
    assign st.zero_sum  = (acc_reg == '0);
    assign st.last_elem = ((CNT_W'(idx_reg) + 1'b1) == count_reg);
    assign st.out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== hdl/sparse_row_l2_normalizer.sv =====
// top level of the sparse row l2 normalizer
// depends on srn_pkg, srn_ctrl and srn_dpath
//
//  channel  signals                       payload     transfer when
//  in       in_valid, in_stall, in_data   in_item_t   in_valid && !in_stall
//  out      out_valid, out_stall, out_data out_item_t out_valid && !out_stall
//
// a pair that is not last in its row is stored and added to the sum as it is taken
// after the last pair each buffered pair goes through a read, a multiply,
//   63 steps of the bit-serial divider and 32 steps of the square root,
//   then into the output register once that is free; a zero row skips
//   divide and root
// in_stall is high from the last pair until the row's final result is loaded
// the output register holds a result while out_stall is high
// reset clears the row count, the sum and the flags; the row buffer is not cleared
module sparse_row_l2_normalizer
    import srn_pkg::*;
#(
    parameter int MAX_ROW_NNZ = MAX_ROW_NNZ_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    // command and status between sequencer and datapath
    cmd_t    cmd;
    status_t st;

    srn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    srn_dpath #(
        .MAX_ROW_NNZ (MAX_ROW_NNZ)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .st        (st),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== bench/srn_checker.sv =====
`timescale 1ns / 1ps
// checker for the sparse row l2 normalizer: watches both channels, predicts rows
// depends on srn_pkg; instantiated by sparse_row_l2_normalizer_tb
module srn_checker
    import srn_pkg::*;
#(
    parameter int ROW_CAP = MAX_ROW_NNZ_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_data,
    output int        fail_count,
    output int        pending_count,
    output int        result_count,
    output int        row_count_seen
);

    logic [VAL_W-1:0] buf_value [ROW_CAP];
    logic [COL_W-1:0] buf_column [ROW_CAP];
    int               held;
    logic [SUM_W-1:0] sum_sq;
    logic             dropped;
    out_item_t        expected_q [$];

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [VAL_W-1:0] normalize(input logic [VAL_W-1:0] raw,
                                                   input logic [SUM_W-1:0] s);
        logic [63:0] mag;
        logic [63:0] q;
        mag = raw[15] ? 64'(17'h10000 - raw) : 64'(raw);
        q = (int_sqrt(((mag * mag) << 32) / 64'(s)) + 1) >> 1;
        if (raw[15])
        begin
            if (q > 32768)
                q = 32768;
            return VAL_W'(17'h10000 - q);
        end
        if (q > 32767)
            q = 32767;
        return VAL_W'(q);
    endfunction

    task automatic report(input string what, input logic [63:0] got,
                          input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    task automatic take_pair(input in_item_t p);
        logic [63:0] mag;
        out_item_t   r;
        if (held < ROW_CAP)
        begin
            mag = p.value[15] ? 64'(17'h10000 - p.value) : 64'(p.value);
            buf_value[held] = p.value;
            buf_column[held] = p.column;
            held++;
            sum_sq = SUM_W'(sum_sq + mag * mag);
        end
        else
            dropped = 1'b1;
        if (p.last_in_row)
        begin
            for (int k = 0; k < held; k++)
            begin
                r.scaled_value = (sum_sq == 0) ? '0 : normalize(buf_value[k], sum_sq);
                r.out_column = buf_column[k];
                r.last_of_row = (k + 1 == held);
                r.row_sum_squares = sum_sq;
                r.zero_row = (sum_sq == 0);
                r.row_overflow = dropped;
                expected_q.insert(expected_q.size(), r);
            end
            row_count_seen++;
            held = 0;
            sum_sq = '0;
            dropped = 1'b0;
        end
    endtask

    task automatic check_result(input out_item_t g);
        out_item_t e;
        if (expected_q.size() == 0)
        begin
            report("unexpected result", 64'(g.out_column), 64'd0);
            return;
        end
        e = expected_q.pop_front();
        result_count++;
        if (g.scaled_value !== e.scaled_value)
            report("scaled_value", 64'(g.scaled_value), 64'(e.scaled_value));
        if (g.out_column !== e.out_column)
            report("out_column", 64'(g.out_column), 64'(e.out_column));
        if (g.last_of_row !== e.last_of_row)
            report("last_of_row", 64'(g.last_of_row), 64'(e.last_of_row));
        if (g.row_sum_squares !== e.row_sum_squares)
            report("row_sum_squares", 64'(g.row_sum_squares), 64'(e.row_sum_squares));
        if (g.zero_row !== e.zero_row)
            report("zero_row", 64'(g.zero_row), 64'(e.zero_row));
        if (g.row_overflow !== e.row_overflow)
            report("row_overflow", 64'(g.row_overflow), 64'(e.row_overflow));
    endtask

    initial
    begin
        fail_count = 0;
        pending_count = 0;
        result_count = 0;
        row_count_seen = 0;
        held = 0;
        sum_sq = '0;
        dropped = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                take_pair(in_data);
            if (out_valid && !out_stall)
                check_result(out_data);
        end
        pending_count = expected_q.size();
    end

endmodule

// ===== bench/sparse_row_l2_normalizer_tb.sv =====
`timescale 1ns / 1ps
// testbench top for the sparse row l2 normalizer: clock, reset, row stimulus, verdict
// depends on srn_pkg, srn_checker and the block itself
module sparse_row_l2_normalizer_tb
    import srn_pkg::*;
();

    localparam int CAP       = MAX_ROW_NNZ_DEF;
    localparam int IDLE_LIMIT = 40000;  // cycles with no transfer on either side

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    int fail_count;
    int pending_count;
    int result_count;
    int row_count_seen;
    int sent;
    bit quiet;       // last part of the run: no idling on either side
    bit hold_sink;   // long receiver hold-off request

    sparse_row_l2_normalizer #(.MAX_ROW_NNZ(CAP)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    srn_checker #(.ROW_CAP(CAP)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count), .row_count_seen(row_count_seen)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // random value biased toward the extremes and small magnitudes
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return VAL_W'($urandom_range(0, 15)) - 16'd8;
            3: return 16'h0000;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // one pair transfer; valid stays high when the next pair follows at once
    task automatic send_pair(input logic [VAL_W-1:0] v, input logic [COL_W-1:0] c,
                             input logic last);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{value: v, column: c, last_in_row: last};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_row(input int len, input int kind);
        logic [VAL_W-1:0] v;
        for (int k = 0; k < len; k++)
        begin
            case (kind)
                1: v = '0;                      // all zero row
                2: v = (k % 2) ? 16'h8000 : 16'h7fff;
                default: v = pick_value();
            endcase
            send_pair(v, COL_W'($urandom), k == len - 1);
        end
    endtask

    // receiver: random stall bursts, plus a long hold-off on request
    initial
    begin
        int burst;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_sink)
            begin
                out_stall <= 1'b1;
                repeat (3000) @(posedge clk);
                out_stall <= 1'b0;
                hold_sink = 1'b0;
                @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                burst = $urandom_range(1, 15);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
                @(posedge clk);
        end
    end

    // watchdog on transfer activity
    initial
    begin
        int idle;
        idle = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int len;
        in_valid = 1'b0;
        in_data = '0;
        rst_n = 1'b0;
        quiet = 1'b0;
        hold_sink = 1'b0;
        sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single pairs at the extremes, zero row, full scale, overflow
        send_pair(16'h7fff, 16'hffff, 1'b1);
        send_pair(16'h8000, 16'h0000, 1'b1);
        send_pair(16'h0001, 16'h5555, 1'b1);
        send_pair(16'hffff, 16'haaaa, 1'b1);
        send_row(3, 1);
        send_row(4, 2);
        send_row(3, 0);
        send_row(CAP + 2, 0);   // last pair itself dropped

        // long receiver hold-off while rows keep coming
        hold_sink = 1'b1;
        send_row(5, 0);
        send_row(6, 0);

        while (sent < 420)
        begin
            if (sent > 330)
                quiet = 1'b1;
            case ($urandom_range(0, 19))
                0: len = CAP + $urandom_range(1, 3);
                1: len = CAP;
                default: len = $urandom_range(1, 8);
            endcase
            send_row(len, ($urandom_range(0, 15) == 0) ? 1 : 0);
        end
        in_valid <= 1'b0;

        // let the checker take in the final pair before watching the drain
        repeat (2) @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("covered %0d pairs in %0d rows, %0d results checked",
                 sent, row_count_seen, result_count);
        if (fail_count == 0 && pending_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
